// ----- src/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion macros; each use stands on a line of its own.
`ifndef SYNTHESIS

// Check prop at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that expr holds in the cycle after cond.
`define ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, cond, expr, msg)

`endif

`endif

// ----- src/svpm_pkg.sv -----
package svpm_pkg;

  localparam int VOLT_WIDTH = 16;
  localparam int FRAC_BITS  = 14;

  // Divider: quotient holds values up to 2^(FRAC_BITS+2)-1, larger ones flag overflow
  localparam int QUOT_W     = FRAC_BITS + 2;
  localparam int NUM_W      = VOLT_WIDTH + FRAC_BITS;
  localparam int CMP_W      = VOLT_WIDTH + QUOT_W;
  localparam int DIV_BITS   = 2;
  localparam int DIV_STAGES = (QUOT_W + DIV_BITS - 1) / DIV_BITS;

  // Normalized magnitude and saturation limits
  localparam int NORM_W = FRAC_BITS + 2;
  localparam logic [NORM_W-1:0] LIM_NEG = NORM_W'(1) << (FRAC_BITS + 1);
  localparam logic [NORM_W-1:0] LIM_POS = LIM_NEG - NORM_W'(1);

  // sqrt(3) in Q30
  localparam int SQRT3_W    = 31;
  localparam int SQRT3_FRAC = 30;
  localparam logic [SQRT3_W-1:0] SQRT3_Q30 = SQRT3_W'(1859775393);
  localparam int PROD_W     = NORM_W + SQRT3_W;

  // Doubled phase voltages and duty intermediates
  localparam int X_W   = FRAC_BITS + 4;
  localparam int D_W   = FRAC_BITS + 7;
  localparam int DCL_W = FRAC_BITS + 4;
  localparam logic signed [D_W-1:0] DUTY_HALF = D_W'(1 <<< (FRAC_BITS + 2));
  localparam logic signed [D_W-1:0] DUTY_FULL = D_W'(1 <<< (FRAC_BITS + 3));
  localparam logic [DCL_W-1:0] DUTY_FULL_U    = DCL_W'(1) << (FRAC_BITS + 3);

  // Q1.16 duty and compare
  localparam int DUTY_FRAC  = 16;
  localparam int DUTY_W     = DUTY_FRAC + 1;
  localparam int DUTY_RSH   = (FRAC_BITS + 3 >= DUTY_FRAC) ? FRAC_BITS + 3 - DUTY_FRAC : 0;
  localparam int DUTY_LSH   = (FRAC_BITS + 3 < DUTY_FRAC) ? DUTY_FRAC - FRAC_BITS - 3 : 0;
  localparam int PERIOD_W   = 16;
  localparam int CMP_OUT_W  = 16;
  localparam int MUL_W      = DUTY_W + PERIOD_W;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000);

  localparam int IN_DATA_W  = ((3 * VOLT_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((3 * CMP_OUT_W + 7) / 8) * 8;

  typedef struct packed {
    logic              neg;
    logic              ovf;
    logic [NUM_W-1:0]  rem;
    logic [QUOT_W-1:0] q;
  } div_state_t;

  typedef struct packed {
    logic              neg;
    logic              ovf;
    logic [QUOT_W-1:0] q;
  } quot_t;

  typedef struct packed {
    logic signed [X_W-1:0] xa;
    logic signed [X_W-1:0] xb;
    logic signed [X_W-1:0] xc;
    logic signed [X_W-1:0] mx;
    logic signed [X_W-1:0] mn;
  } phase_t;

  // Split sign, scale magnitude, flag a quotient too big for QUOT_W bits
  function automatic div_state_t div_prep(input logic [VOLT_WIDTH-1:0] v,
                                          input logic [VOLT_WIDTH-1:0] d);
    div_state_t r;
    logic [VOLT_WIDTH-1:0] mag;
    r.neg = v[VOLT_WIDTH-1];
    mag   = r.neg ? (~v + 1'b1) : v;
    r.rem = NUM_W'(mag) << FRAC_BITS;
    r.ovf = (CMP_W'(r.rem) >= (CMP_W'(d) << QUOT_W));
    r.q   = '0;
    return r;
  endfunction

  // Restoring division, DIV_BITS quotient bits from the top down
  function automatic div_state_t div_iter(input div_state_t st,
                                          input logic [VOLT_WIDTH-1:0] d,
                                          input int stg);
    div_state_t r;
    logic [CMP_W-1:0] sh;
    int idx;
    r = st;
    for (int k = 0; k < DIV_BITS; k++) begin
      idx = QUOT_W - 1 - stg * DIV_BITS - k;
      if (idx >= 0) begin
        sh = CMP_W'(d) << idx;
        if (CMP_W'(r.rem) >= sh) begin
          r.rem = r.rem - NUM_W'(sh);
          r.q   = {r.q[QUOT_W-2:0], 1'b1};
        end else begin
          r.q   = {r.q[QUOT_W-2:0], 1'b0};
        end
      end
    end
    return r;
  endfunction

  function automatic logic [NORM_W-1:0] sat_mag(input quot_t qt);
    logic [NORM_W-1:0] lim;
    lim = qt.neg ? LIM_NEG : LIM_POS;
    return (qt.ovf || (NORM_W'(qt.q) > lim)) ? lim : NORM_W'(qt.q);
  endfunction

  // Duty in units of 2^-(FRAC_BITS+3), clamped to [0,1], then moved to Q1.16
  function automatic logic [DUTY_W-1:0] duty_of(input logic signed [X_W-1:0] x,
                                                input logic signed [X_W-1:0] mx,
                                                input logic signed [X_W-1:0] mn);
    logic signed [D_W-1:0] d;
    logic [DCL_W-1:0] dcl;
    logic [63:0] w;
    d = DUTY_HALF + (D_W'(x) <<< 1) - D_W'(mx) - D_W'(mn);
    priority if (d < 0) begin
      dcl = '0;
    end else if (d > DUTY_FULL) begin
      dcl = DUTY_FULL_U;
    end else begin
      dcl = DCL_W'(d);
    end
    w = (64'(dcl) >> DUTY_RSH) << DUTY_LSH;
    return DUTY_W'(w);
  endfunction

endpackage

// ----- src/svpm_norm.sv -----
module svpm_norm (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [svpm_pkg::VOLT_WIDTH-1:0]  v_alpha,
  input  logic [svpm_pkg::VOLT_WIDTH-1:0]  v_beta,
  input  logic [svpm_pkg::VOLT_WIDTH-1:0]  bus_voltage,
  output logic                             out_valid,
  input  logic                             out_ready,
  output svpm_pkg::quot_t                  qa,
  output svpm_pkg::quot_t                  qb
);
  import svpm_pkg::*;

  localparam int NS = DIV_STAGES + 1;

  logic [NS-1:0] vld_r, vld_nxt, vld_in;
  logic [NS:0]   adv;

  div_state_t            da_r   [NS];
  div_state_t            db_r   [NS];
  logic [VOLT_WIDTH-1:0] bus_r  [NS];
  div_state_t            da_nxt [NS];
  div_state_t            db_nxt [NS];
  logic [VOLT_WIDTH-1:0] bus_nz;

  always_comb begin
    adv[NS] = out_ready;
    for (int s = NS - 1; s >= 0; s--) begin
      adv[s] = !vld_r[s] || adv[s+1];
    end
    vld_in = {vld_r[NS-2:0], in_valid};
    for (int s = 0; s < NS; s++) begin
      vld_nxt[s] = adv[s] ? vld_in[s] : vld_r[s];
    end
  end

  assign in_ready = adv[0];

  // Zero bus counts as one LSB
  assign bus_nz = (bus_voltage == '0) ? VOLT_WIDTH'(1) : bus_voltage;

  always_comb begin
    da_nxt[0] = div_prep(v_alpha, bus_nz);
    db_nxt[0] = div_prep(v_beta, bus_nz);
    for (int s = 1; s < NS; s++) begin
      da_nxt[s] = div_iter(da_r[s-1], bus_r[s-1], s - 1);
      db_nxt[s] = div_iter(db_r[s-1], bus_r[s-1], s - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      bus_r[0] <= bus_nz;
    end
    for (int s = 1; s < NS; s++) begin
      if (adv[s]) begin
        bus_r[s] <= bus_r[s-1];
      end
    end
    for (int s = 0; s < NS; s++) begin
      if (adv[s]) begin
        da_r[s] <= da_nxt[s];
        db_r[s] <= db_nxt[s];
      end
    end
  end

  assign out_valid = vld_r[NS-1];
  assign qa = '{neg: da_r[NS-1].neg, ovf: da_r[NS-1].ovf, q: da_r[NS-1].q};
  assign qb = '{neg: db_r[NS-1].neg, ovf: db_r[NS-1].ovf, q: db_r[NS-1].q};

endmodule

// ----- src/svpm_phase.sv -----
module svpm_phase (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  svpm_pkg::quot_t  qa,
  input  svpm_pkg::quot_t  qb,
  output logic             out_valid,
  input  logic             out_ready,
  output svpm_pkg::phase_t ph
);
  import svpm_pkg::*;

  localparam int NS = 4;

  logic [NS-1:0] vld_r, vld_nxt, vld_in;
  logic [NS:0]   adv;

  // Stage 1: saturate
  logic signed [NORM_W-1:0] a1_r, a1_nxt;
  logic [NORM_W-1:0]        bmag1_r, amag, bmag;
  logic                     bneg1_r;
  // Stage 2: beta times sqrt(3)
  logic signed [NORM_W-1:0] a2_r;
  logic                     bneg2_r;
  logic [PROD_W-1:0]        prod2_r, prod2_nxt;
  // Stage 3: inverse Clarke, doubled
  logic [NORM_W-1:0]        s3;
  logic signed [X_W-1:0]    sx, ax;
  logic signed [X_W-1:0]    xa3_r, xb3_r, xc3_r, xa3_nxt, xb3_nxt, xc3_nxt;
  // Stage 4: min/max
  phase_t                   ph_r, ph_nxt;

  always_comb begin
    adv[NS] = out_ready;
    for (int s = NS - 1; s >= 0; s--) begin
      adv[s] = !vld_r[s] || adv[s+1];
    end
    vld_in = {vld_r[NS-2:0], in_valid};
    for (int s = 0; s < NS; s++) begin
      vld_nxt[s] = adv[s] ? vld_in[s] : vld_r[s];
    end
  end

  assign in_ready = adv[0];

  always_comb begin
    amag      = sat_mag(qa);
    bmag      = sat_mag(qb);
    a1_nxt    = qa.neg ? (~amag + 1'b1) : amag;
    prod2_nxt = PROD_W'(bmag1_r) * PROD_W'(SQRT3_Q30);

    // Round half away from zero on the magnitude
    s3      = NORM_W'((prod2_r + (PROD_W'(1) << (SQRT3_FRAC - 1))) >> SQRT3_FRAC);
    sx      = bneg2_r ? -X_W'(s3) : X_W'(s3);
    ax      = X_W'(a2_r);
    xa3_nxt = ax <<< 1;
    xb3_nxt = sx - ax;
    xc3_nxt = -ax - sx;

    ph_nxt.xa = xa3_r;
    ph_nxt.xb = xb3_r;
    ph_nxt.xc = xc3_r;
    ph_nxt.mx = xa3_r;
    ph_nxt.mn = xa3_r;
    if (xb3_r > ph_nxt.mx) ph_nxt.mx = xb3_r;
    if (xc3_r > ph_nxt.mx) ph_nxt.mx = xc3_r;
    if (xb3_r < ph_nxt.mn) ph_nxt.mn = xb3_r;
    if (xc3_r < ph_nxt.mn) ph_nxt.mn = xc3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      a1_r    <= a1_nxt;
      bmag1_r <= bmag;
      bneg1_r <= qb.neg;
    end
    if (adv[1]) begin
      a2_r    <= a1_r;
      bneg2_r <= bneg1_r;
      prod2_r <= prod2_nxt;
    end
    if (adv[2]) begin
      xa3_r <= xa3_nxt;
      xb3_r <= xb3_nxt;
      xc3_r <= xc3_nxt;
    end
    if (adv[3]) begin
      ph_r <= ph_nxt;
    end
  end

  assign out_valid = vld_r[NS-1];
  assign ph        = ph_r;

endmodule

// ----- src/svpm_duty.sv -----
module svpm_duty (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  svpm_pkg::phase_t                ph,
  input  logic [svpm_pkg::PERIOD_W-1:0]   timer_period,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [svpm_pkg::CMP_OUT_W-1:0]  compare_a,
  output logic [svpm_pkg::CMP_OUT_W-1:0]  compare_b,
  output logic [svpm_pkg::CMP_OUT_W-1:0]  compare_c
);
  import svpm_pkg::*;

  localparam int NS = 2;

  logic [NS-1:0] vld_r, vld_nxt, vld_in;
  logic [NS:0]   adv;

  logic [DUTY_W-1:0]    da_r, db_r, dc_r;
  logic [MUL_W-1:0]     pa, pb, pc;
  logic [CMP_OUT_W-1:0] ca_r, cb_r, cc_r;

  always_comb begin
    adv[NS] = out_ready;
    for (int s = NS - 1; s >= 0; s--) begin
      adv[s] = !vld_r[s] || adv[s+1];
    end
    vld_in = {vld_r[NS-2:0], in_valid};
    for (int s = 0; s < NS; s++) begin
      vld_nxt[s] = adv[s] ? vld_in[s] : vld_r[s];
    end
  end

  assign in_ready = adv[0];

  assign pa = MUL_W'(da_r) * MUL_W'(timer_period);
  assign pb = MUL_W'(db_r) * MUL_W'(timer_period);
  assign pc = MUL_W'(dc_r) * MUL_W'(timer_period);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      da_r <= duty_of(ph.xa, ph.mx, ph.mn);
      db_r <= duty_of(ph.xb, ph.mx, ph.mn);
      dc_r <= duty_of(ph.xc, ph.mx, ph.mn);
    end
    if (adv[1]) begin
      ca_r <= pa[DUTY_FRAC +: CMP_OUT_W];
      cb_r <= pb[DUTY_FRAC +: CMP_OUT_W];
      cc_r <= pc[DUTY_FRAC +: CMP_OUT_W];
    end
  end

  assign out_valid = vld_r[NS-1];
  assign compare_a = ca_r;
  assign compare_b = cb_r;
  assign compare_c = cc_r;

endmodule

// ----- src/svpwm_minmax_duty.sv -----
// Pipeline: 15 register stages; a result shows on out_tvalid from the last of them.
// Throughput: one request per cycle while the output is not stalled; each of the 15 register stages holds one request.
// Depth is set by the restoring divider: 16 quotient bits, 2 per stage, 9 stages with setup.
// Back-pressure stalls only the stages that are full; bubbles close up.
// Reset (rst_n low at a clock edge): drop all requests in flight, set the timer period to 1000.
`include "assert_macros.svh"

module svpwm_minmax_duty (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [15:0] v_alpha_in, [31:16] v_beta_in, [47:32] bus_voltage
  input  logic [svpm_pkg::IN_DATA_W-1:0]   in_tdata,
  // Result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [15:0] compare_a, [31:16] compare_b, [47:32] compare_c
  output logic [svpm_pkg::OUT_DATA_W-1:0]  out_tdata,
  // Period register write
  input  logic                             cfg_we,
  input  logic [svpm_pkg::PERIOD_W-1:0]    cfg_wdata
);
  import svpm_pkg::*;

  logic [PERIOD_W-1:0] period_r;

  logic [VOLT_WIDTH-1:0] v_alpha_in, v_beta_in, bus_voltage;

  logic   nrm_valid, nrm_ready;
  quot_t  nrm_qa, nrm_qb;
  logic   ph_valid, ph_ready;
  phase_t ph_data;

  logic [CMP_OUT_W-1:0] compare_a, compare_b, compare_c;

  // Unpack the request fields
  assign v_alpha_in  = in_tdata[VOLT_WIDTH-1:0];
  assign v_beta_in   = in_tdata[2*VOLT_WIDTH-1:VOLT_WIDTH];
  assign bus_voltage = in_tdata[3*VOLT_WIDTH-1:2*VOLT_WIDTH];

  // Period register; write it only while the pipeline is empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
    end else if (cfg_we) begin
      period_r <= cfg_wdata;
    end
  end

  // Divide alpha and beta by the bus voltage (sign, magnitude, overflow flag)
  svpm_norm u_norm (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .v_alpha     (v_alpha_in),
    .v_beta      (v_beta_in),
    .bus_voltage (bus_voltage),
    .out_valid   (nrm_valid),
    .out_ready   (nrm_ready),
    .qa          (nrm_qa),
    .qb          (nrm_qb)
  );

  // Saturate, inverse Clarke on doubled voltages, find max and min
  svpm_phase u_phase (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (nrm_valid),
    .in_ready  (nrm_ready),
    .qa        (nrm_qa),
    .qb        (nrm_qb),
    .out_valid (ph_valid),
    .out_ready (ph_ready),
    .ph        (ph_data)
  );

  // Inject zero sequence, clamp duty, scale by period; last stage is the output register
  svpm_duty u_duty (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (ph_valid),
    .in_ready     (ph_ready),
    .ph           (ph_data),
    .timer_period (period_r),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .compare_a    (compare_a),
    .compare_b    (compare_b),
    .compare_c    (compare_c)
  );

  assign out_tdata = OUT_DATA_W'({compare_c, compare_b, compare_a});

  // The input stalls only when every stage is full and the result is not taken
  `ASSERT_CLK(a_stall_needs_full_out, clk, rst_n, !in_tready |-> out_tvalid && !out_tready, "input stalled while output free")
  // A stalled quotient must hold across the divider/phase boundary
  `ASSERT_NEXT(a_norm_hold, clk, rst_n, nrm_valid && !nrm_ready, nrm_valid && $stable(nrm_qa) && $stable(nrm_qb), "quotient changed under stall")
  // A stalled phase set must hold across the phase/duty boundary
  `ASSERT_NEXT(a_phase_hold, clk, rst_n, ph_valid && !ph_ready, ph_valid && $stable(ph_data), "phase data changed under stall")

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

  // Predictor constants; the fraction width comes from the package, the rest are set here
  localparam int FB = svpm_pkg::FRAC_BITS;
  localparam longint NORM_MAX_POS = (64'sd1 <<< (FB + 1)) - 64'sd1;
  localparam longint NORM_MAX_NEG = 64'sd1 <<< (FB + 1);
  localparam longint ROOT3_Q30 = 64'sd1859775393;

  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 290;
  localparam int HOLD_CYCLES     = 120;
  localparam int SETTLE_CYCLES   = 20;   // a little over the 15-stage pipeline
  localparam int DRAIN_LIMIT     = 20000;

  // One directed request; the compare values count only when typed is set
  typedef struct packed {
    logic signed [15:0] va;
    logic signed [15:0] vb;
    logic [15:0]        bus;
    logic               typed;
    logic [15:0]        want_a;
    logic [15:0]        want_b;
    logic [15:0]        want_c;
  } dir_row_t;

  logic                             clk;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [svpm_pkg::IN_DATA_W-1:0]   in_tdata = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [svpm_pkg::OUT_DATA_W-1:0]  out_tdata;
  logic                             cfg_we = 1'b0;
  logic [svpm_pkg::PERIOD_W-1:0]    cfg_wdata = '0;

  // Expected compare triples, {c, b, a}, oldest first
  logic [47:0]  pending_compares [$];
  logic [47:0]  expected_cmp;
  longint       period_now = longint'(svpm_pkg::PERIOD_RESET);
  int unsigned  tx_idle_pct = 0;
  int unsigned  rx_idle_pct = 0;
  int           hold_issued = 0;
  int           hold_done = 0;
  int           error_count = 0;
  int           requests_sent = 0;
  int           results_checked = 0;
  int           in_stalls = 0;

  // Extremes, zero bus, saturation and over-modulation; the first three and the
  // last can be read off by hand at the reset period of 1000.
  dir_row_t directed_rows [20] = '{
    '{0,      0,      1000,  1'b1, 500,  500,  500},
    '{32767,  0,      0,     1'b1, 1000, 0,    0},
    '{-32768, 0,      0,     1'b1, 0,    1000, 1000},
    '{0,      32767,  0,     1'b0, 0,    0,    0},
    '{0,      -32768, 0,     1'b0, 0,    0,    0},
    '{32767,  32767,  65535, 1'b0, 0,    0,    0},
    '{-32768, -32768, 65535, 1'b0, 0,    0,    0},
    '{1000,   0,      1000,  1'b0, 0,    0,    0},
    '{-1000,  0,      1000,  1'b0, 0,    0,    0},
    '{0,      1000,   1000,  1'b0, 0,    0,    0},
    '{500,    866,    1000,  1'b0, 0,    0,    0},
    '{-500,   -866,   1000,  1'b0, 0,    0,    0},
    '{16384,  -16384, 32768, 1'b0, 0,    0,    0},
    '{1,      1,      65535, 1'b0, 0,    0,    0},
    '{-1,     -1,     1,     1'b0, 0,    0,    0},
    '{32767,  -32768, 1,     1'b0, 0,    0,    0},
    '{12345,  -23456, 40000, 1'b0, 0,    0,    0},
    '{30000,  17320,  20000, 1'b0, 0,    0,    0},
    '{-21845, 21845,  65535, 1'b0, 0,    0,    0},
    '{0,      0,      0,     1'b1, 500,  500,  500}
  };

  svpwm_minmax_duty dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Normalize one command by the bus voltage: truncate toward zero, then
  // saturate to the Q2.14 range (one more step allowed on the negative side).
  function automatic longint scaled_volt(input longint v, input longint bus);
    longint mag;
    longint q;
    mag = (v < 0) ? -v : v;
    q = (mag <<< FB) / bus;
    if (v < 0) begin
      return (q > NORM_MAX_NEG) ? -NORM_MAX_NEG : -q;
    end
    return (q > NORM_MAX_POS) ? NORM_MAX_POS : q;
  endfunction

  // Duty from the doubled phase voltage and the min/max midpoint, clamped to
  // [0, 1], moved to Q1.16 and scaled by the period.
  function automatic logic [15:0] phase_compare(input longint x2, input longint hi,
                                                input longint lo);
    longint d;
    d = (64'sd1 <<< (FB + 2)) + 2 * x2 - hi - lo;
    if (d < 0) begin
      d = 0;
    end
    if (d > (64'sd1 <<< (FB + 3))) begin
      d = 64'sd1 <<< (FB + 3);
    end
    d = (d >>> svpm_pkg::DUTY_RSH) <<< svpm_pkg::DUTY_LSH;
    return 16'((d * period_now) >>> 16);
  endfunction

  // Expected {compare_c, compare_b, compare_a} for one request
  function automatic logic [47:0] svpwm_compares(input logic signed [15:0] va,
                                                 input logic signed [15:0] vb,
                                                 input logic [15:0] bus_raw);
    longint bus, a, b, mag, s, xa, xb, xc, hi, lo;
    bus = (bus_raw == 16'd0) ? 64'sd1 : longint'(bus_raw);
    a = scaled_volt(longint'(va), bus);
    b = scaled_volt(longint'(vb), bus);
    // beta * sqrt(3), rounded half away from zero
    mag = (b < 0) ? -b : b;
    s = (mag * ROOT3_Q30 + (64'sd1 <<< 29)) >>> 30;
    if (b < 0) begin
      s = -s;
    end
    // inverse Clarke, all phases doubled
    xa = 2 * a;
    xb = -a + s;
    xc = -a - s;
    hi = xa;
    lo = xa;
    if (xb > hi) hi = xb;
    if (xc > hi) hi = xc;
    if (xb < lo) lo = xb;
    if (xc < lo) lo = xc;
    return {phase_compare(xc, hi, lo), phase_compare(xb, hi, lo), phase_compare(xa, hi, lo)};
  endfunction

  // Random request {bus, beta, alpha}: mostly commands within the bus range,
  // the rest tiny buses that force saturation and fully random words.
  function automatic logic [47:0] random_voltages();
    int unsigned pick;
    int unsigned lim;
    logic [15:0] bus;
    int va;
    int vb;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      bus = 16'($urandom_range(1000, 65535));
      lim = (bus > 16'd32767) ? 32767 : int'(bus);
      va = int'($urandom_range(0, 2 * lim)) - int'(lim);
      vb = int'($urandom_range(0, 2 * lim)) - int'(lim);
    end else if (pick < 75) begin
      bus = 16'($urandom_range(0, 64));
      va = $urandom;
      vb = $urandom;
    end else begin
      bus = 16'($urandom);
      va = $urandom;
      vb = $urandom;
    end
    return {bus, 16'(vb), 16'(va)};
  endfunction

  // Offer one request, idling at random first; record its expectation once
  // the block takes it.
  task automatic send_request(input logic [47:0] req, input logic [47:0] want);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= req;
    do begin
      @(posedge clk);
    end while (!in_tready);
    pending_compares.push_back(want);
    requests_sent++;
  endtask

  // Stop offering and wait for every outstanding result, then settle
  task automatic await_results(input int settle);
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (pending_compares.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_period(input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    period_now = longint'(value);
  endtask

  // Receiver: random back-pressure, plus a long hold when the stimulus asks
  // for one, so the pipeline fills and stalls its input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_done != hold_issued) begin
        hold_done = hold_issued;
        repeat (HOLD_CYCLES) begin
          out_tready <= 1'b0;
          @(posedge clk);
        end
      end
      out_tready <= rst_n && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Check every accepted result against the oldest expectation, field by field
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_compares.size() == 0) begin
        $display("%0t: unexpected result, got %h", $time, out_tdata);
        error_count++;
      end else begin
        expected_cmp = pending_compares.pop_front();
        results_checked++;
        for (int k = 0; k < 3; k++) begin
          if (out_tdata[16*k +: 16] !== expected_cmp[16*k +: 16]) begin
            $display("%0t: compare_%s mismatch: expected %0d, got %0d", $time,
                     (k == 0) ? "a" : (k == 1) ? "b" : "c",
                     expected_cmp[16*k +: 16], out_tdata[16*k +: 16]);
            error_count++;
          end
        end
      end
    end
  end

  // Count cycles where the block holds off a pending request
  always @(posedge clk) begin
    if (rst_n && in_tvalid && !in_tready) begin
      in_stalls++;
    end
  end

  initial begin
    logic [47:0] req;
    logic [47:0] want;
    logic [15:0] periods [NUM_PHASES];
    // extremes first, zero period in the middle, one random setting
    periods = '{16'd65535, 16'd1, 16'd0, 16'($urandom_range(2, 65534)), 16'd1000, 16'd32768};

    // Hold reset, then release it
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table at the reset period: sender idles lightly, receiver heavily
    tx_idle_pct = 16;
    rx_idle_pct = 88;
    foreach (directed_rows[i]) begin
      req = {directed_rows[i].bus, directed_rows[i].vb, directed_rows[i].va};
      if (directed_rows[i].typed) begin
        want = {directed_rows[i].want_c, directed_rows[i].want_b, directed_rows[i].want_a};
      end else begin
        want = svpwm_compares(directed_rows[i].va, directed_rows[i].vb, directed_rows[i].bus);
      end
      send_request(req, want);
    end
    await_results(SETTLE_CYCLES);

    // Random phases, one period setting each; swap idling after two phases,
    // then run flat out for the last two.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      tx_idle_pct = (ph < 2) ? 16 : (ph < 4) ? 88 : 0;
      rx_idle_pct = (ph < 2) ? 88 : (ph < 4) ? 16 : 0;
      write_period(periods[ph]);
      // long receiver hold while requests keep coming
      if (ph == 4) begin
        hold_issued++;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // pause the sender until the pipeline has emptied
        if (n == ITEMS_PER_PHASE / 2 && (ph == 1 || ph == 5)) begin
          await_results(0);
        end
        req = random_voltages();
        send_request(req, svpwm_compares(req[15:0], req[31:16], req[47:32]));
      end
      await_results(SETTLE_CYCLES);
    end

    if (pending_compares.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_compares.size());
      error_count += pending_compares.size();
    end
    $display("Sent %0d requests and checked %0d results over %0d period settings,",
             requests_sent, results_checked, NUM_PHASES + 1);
    $display("including 0, 1 and 65535; input held off on %0d cycles.", in_stalls);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- svpwm_minmax_duty.f -----
+incdir+src
src/svpm_pkg.sv
src/svpm_norm.sv
src/svpm_phase.sv
src/svpm_duty.sv
src/svpwm_minmax_duty.sv
tb/tb.sv
